// File: design/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared constants and types of the running median tracker.
// ----------------------------------------------------------------------------
package rmt_pkg;

	localparam int RMT_CAPACITY    = 64;
	localparam int RMT_SAMPLE_BITS = 32;

	// fixed widths of the channel fields
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int COUNT_W  = 7;

	// handed from one cell to the next one down the chain
	typedef struct packed {
		logic shift;
		logic occ;
	} rmt_link_t;

endpackage

// File: design/rmt_ifs.sv
// ----------------------------------------------------------------------------
// rmt_ifs
// Valid/ready channels of the running median tracker.
// ----------------------------------------------------------------------------
interface rmt_sample_if;
	import rmt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmt_median_if;
	import rmt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [MEDIAN_W-1:0] median_doubled;
	logic        [COUNT_W-1:0]  held_count;
	logic                       dropped;

	modport source (output valid, output median_doubled, output held_count,
		output dropped, input ready);
	modport sink   (input valid, input median_doubled, input held_count,
		input dropped, output ready);
endinterface

// File: design/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell
// One slot of the sorted insertion chain: compares the new sample with its
// value and either keeps it, takes the neighbor's value or takes the sample.
// ----------------------------------------------------------------------------
module rmt_cell #(
	parameter int W = rmt_pkg::RMT_SAMPLE_BITS
) (
	input  logic                clk,
	input  logic                ins,
	input  logic signed [W-1:0] sample,
	input  logic                occ,
	input  rmt_pkg::rmt_link_t  up,
	input  logic signed [W-1:0] up_value,
	output rmt_pkg::rmt_link_t  down,
	output logic signed [W-1:0] value
);
	import rmt_pkg::*;

	logic signed [W-1:0] value_q;
	logic                shift;
	logic                load_new;

	// equal values stay ahead of the new sample
	assign shift    = occ && (value_q > sample);
	assign load_new = !up.shift && (shift || (!occ && up.occ));

	always_ff @(posedge clk) begin
		if (ins) begin
			if (up.shift) begin
				value_q <= up_value;
			end else if (load_new) begin
				value_q <= sample;
			end
		end
	end

	assign down.shift = shift;
	assign down.occ   = occ;
	assign value      = value_q;

endmodule

// File: design/running_median_tracker_unit.sv
// ----------------------------------------------------------------------------
// running_median_tracker_unit
// Running median of a signed sample stream over a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one beat per sample: the low SAMPLE_BITS bits of sample,
//   read as two's complement, and restart, which empties the store before
//   the sample is taken. medians returns one beat per sample: twice the
//   median of the stored samples, the number held and a dropped flag that is
//   set when the store was full and the sample was discarded.
//   When a sample is inserted, all CAPACITY cells compare it with their
//   value at once, and those behind the insertion point move one slot down.
//   The two middle entries are then read into the s2 registers, and their
//   sum is registered into the output register.
//   One sample per cycle is taken while medians is not stalled.
//   When the receiver stalls, the output register holds its beat, the whole
//   pipeline freezes and samples.ready drops until the beat is taken.
//   Reset empties the store and the pipeline at once; no clearing pass is
//   needed since only the occupied part of the chain feeds a valid median.
// ----------------------------------------------------------------------------
module running_median_tracker_unit #(
	parameter int CAPACITY    = rmt_pkg::RMT_CAPACITY,
	parameter int SAMPLE_BITS = rmt_pkg::RMT_SAMPLE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	rmt_sample_if.sink          samples,
	rmt_median_if.source        medians
);
	import rmt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic                          advance;
	logic                          accept;
	logic                          ins;
	logic                          drop;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_eff;
	logic signed [SAMPLE_BITS-1:0] smp;

	rmt_link_t                     link [CAPACITY+1];
	logic signed [SAMPLE_BITS-1:0] cell_value [CAPACITY];
	logic signed [SAMPLE_BITS-1:0] up_value [CAPACITY];

	logic                          v_s1;
	logic [CW-1:0]                 count_s1;
	logic                          drop_s1;

	logic                          v_s2;
	logic [CW-1:0]                 count_s2;
	logic                          drop_s2;
	logic signed [SAMPLE_BITS-1:0] lo_s2;
	logic signed [SAMPLE_BITS-1:0] hi_s2;

	logic [IW-1:0]                 mid_hi;
	logic [IW-1:0]                 mid_lo;
	logic signed [SAMPLE_BITS:0]   sum;

	logic                          out_v_q;
	logic signed [MEDIAN_W-1:0]    median_q;
	logic [COUNT_W-1:0]            held_q;
	logic                          dropped_q;

	assign advance       = !out_v_q || medians.ready;
	assign samples.ready = advance;
	assign accept        = samples.valid && advance;

	assign smp       = samples.sample[SAMPLE_BITS-1:0];
	assign count_eff = samples.restart ? '0 : count_q;
	assign drop      = (count_eff == CW'(CAPACITY));
	assign ins       = accept && !drop;

	// head of the chain: nothing shifts in, and slot zero counts as the
	// first free slot when the store is empty
	assign link[0] = '{shift: 1'b0, occ: 1'b1};

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign up_value[i] = smp;
			end else begin : g_body
				assign up_value[i] = cell_value[i-1];
			end
			rmt_cell #(.W(SAMPLE_BITS)) u_cell (
				.clk      (clk),
				.ins      (ins),
				.sample   (smp),
				.occ      (count_eff > CW'(i)),
				.up       (link[i]),
				.up_value (up_value[i]),
				.down     (link[i+1]),
				.value    (cell_value[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= drop ? count_eff : count_eff + CW'(1);
		end
	end

	// middle entries of the chain as it stands after the item in s1
	assign mid_hi = IW'(count_q >> 1);
	assign mid_lo = count_q[0] ? mid_hi : mid_hi - IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= samples.valid;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			count_s1 <= drop ? count_eff : count_eff + CW'(1);
			drop_s1  <= drop;
			count_s2 <= count_s1;
			drop_s2  <= drop_s1;
			lo_s2    <= cell_value[mid_lo];
			hi_s2    <= cell_value[mid_hi];
		end
	end

	assign sum = (SAMPLE_BITS + 1)'(lo_s2) + (SAMPLE_BITS + 1)'(hi_s2);

	always_ff @(posedge clk) begin
		if (advance) begin
			median_q  <= MEDIAN_W'(sum);
			held_q    <= COUNT_W'(count_s2);
			dropped_q <= drop_s2;
		end
	end

	assign medians.valid          = out_v_q;
	assign medians.median_doubled = median_q;
	assign medians.held_count     = held_q;
	assign medians.dropped        = dropped_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("store count above capacity");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && drop_s1 |-> count_q == CW'(CAPACITY))
		else $error("drop flagged with room in the store");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !samples.restart && count_q != CW'(CAPACITY)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("count did not grow on insertion");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> cell_value[0] <= cell_value[1])
		else $error("chain head out of order");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !medians.ready |=> $stable(count_q) && $stable(v_s1))
		else $error("pipeline moved while output stalled");
`endif

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the running median tracker: a short directed run
// over the sample extremes and restarts, then random runs of mixed length,
// some filling the store, with random stalls on both channels. Every median
// beat is checked against a sorted-store predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
	import rmt_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int IDLE_PCT     = 37;
	localparam int QUIET_FROM   = 500;
	localparam int QUIET_TO     = 900;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} sample_beat_t;

	typedef struct {
		logic signed [MEDIAN_W-1:0] median_doubled;
		logic        [COUNT_W-1:0]  held_count;
		logic                       dropped;
	} median_beat_t;

	class median_scoreboard;
		logic signed [SAMPLE_W-1:0] sorted_vals [RMT_CAPACITY];
		int                         held;
		median_beat_t               awaited [$];
		int                         errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		// insert into the sorted copy and queue the median it leads to
		function void note_sample(logic signed [SAMPLE_W-1:0] raw, logic restart);
			logic signed [SAMPLE_W-1:0] v;
			logic signed [MEDIAN_W-1:0] lo;
			logic signed [MEDIAN_W-1:0] hi;
			median_beat_t               exp;
			int                         pos;

			// keep only the low sample bits, as two's complement
			v = raw <<< (SAMPLE_W - RMT_SAMPLE_BITS);
			v = v >>> (SAMPLE_W - RMT_SAMPLE_BITS);
			exp.dropped = 1'b0;
			if (restart)
				held = 0;
			if (held >= RMT_CAPACITY) begin
				exp.dropped = 1'b1;
			end else begin
				pos = 0;
				while (pos < held && sorted_vals[pos] <= v)
					pos++;
				for (int i = held; i > pos; i--)
					sorted_vals[i] = sorted_vals[i-1];
				sorted_vals[pos] = v;
				held++;
			end
			if (held == 0) begin
				exp.median_doubled = '0;
			end else if (held % 2 == 1) begin
				lo = sorted_vals[held/2];
				exp.median_doubled = lo + lo;
			end else begin
				lo = sorted_vals[held/2 - 1];
				hi = sorted_vals[held/2];
				exp.median_doubled = lo + hi;
			end
			exp.held_count = COUNT_W'(held);
			awaited.insert(awaited.size(), exp);
		endfunction

		function void check_result(logic signed [MEDIAN_W-1:0] md, logic [COUNT_W-1:0] cnt,
				logic drp);
			median_beat_t exp;

			if (awaited.size() == 0) begin
				$error("median beat with no sample pending: median_doubled %0d", md);
				errors++;
				return;
			end
			exp = awaited.pop_front();
			if (md !== exp.median_doubled) begin
				$error("median_doubled: expected %0d, got %0d", exp.median_doubled, md);
				errors++;
			end
			if (cnt !== exp.held_count) begin
				$error("held_count: expected %0d, got %0d", exp.held_count, cnt);
				errors++;
			end
			if (drp !== exp.dropped) begin
				$error("dropped: expected %0d, got %0d", exp.dropped, drp);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;

	rmt_sample_if samples_ch ();
	rmt_median_if medians_ch ();

	running_median_tracker_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.medians (medians_ch)
	);

	median_scoreboard sb;
	sample_beat_t     stim [$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit idle_now();
		if (cycles >= QUIET_FROM && cycles < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int kind;

		kind = $urandom_range(0, 3);
		if (kind == 0)
			return $urandom;
		if (kind == 1)
			return $urandom_range(0, 40) - 20;
		if (kind == 2) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sh00000000;
				default: return 32'shFFFFFFFF;
			endcase
		end
		if ($urandom_range(0, 1))
			return 32'sh7FFFFFFF - $urandom_range(0, 7);
		return 32'sh80000000 + $urandom_range(0, 7);
	endfunction

	function automatic void push_beat(logic signed [SAMPLE_W-1:0] s, logic r);
		sample_beat_t b;

		b.sample  = s;
		b.restart = r;
		stim.insert(stim.size(), b);
	endfunction

	task automatic build_stimulus();
		int made;
		int run_len;
		logic r;

		// extremes, overflow of the middle sum, equal values, restarts
		push_beat(32'sh7FFFFFFF, 1'b0);
		push_beat(32'sh7FFFFFFF, 1'b0);
		push_beat(32'sh80000000, 1'b1);
		push_beat(32'sh80000000, 1'b0);
		push_beat(32'sh00000000, 1'b0);
		push_beat(32'shFFFFFFFF, 1'b0);
		push_beat(32'sh00000001, 1'b0);
		push_beat(32'sh00000000, 1'b1);
		push_beat(32'shFFFFFFFF, 1'b0);
		push_beat(32'sh7FFFFFFF, 1'b1);
		push_beat(32'sh80000000, 1'b0);
		push_beat(32'shAAAAAAAA, 1'b1);
		push_beat(32'sh55555555, 1'b0);
		push_beat(32'sh00000005, 1'b1);
		push_beat(32'sh00000005, 1'b0);
		push_beat(32'sh00000005, 1'b0);
		push_beat(32'sh00000004, 1'b0);
		push_beat(32'sh00000006, 1'b0);

		// runs of samples, some long enough to fill the store and overflow it
		made = 0;
		while (made < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				run_len = $urandom_range(RMT_CAPACITY - 4, RMT_CAPACITY + 8);
			else
				run_len = $urandom_range(1, 24);
			for (int i = 0; i < run_len && made < RANDOM_ITEMS; i++) begin
				if (i == 0)
					r = ($urandom_range(0, 9) != 0);
				else
					r = ($urandom_range(0, 99) < 3);
				push_beat(pick_sample(), r);
				made++;
			end
		end
	endtask

	task automatic send_sample(sample_beat_t b);
		while (idle_now()) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid   <= 1'b1;
		samples_ch.sample  <= b.sample;
		samples_ch.restart <= b.restart;
		do
			@(posedge clk);
		while (!samples_ch.ready);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk)
		medians_ch.ready <= !idle_now();

	// sample both channels before the edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_ch.valid && samples_ch.ready)
				sb.note_sample(samples_ch.sample, samples_ch.restart);
			if (medians_ch.valid && medians_ch.ready)
				sb.check_result(medians_ch.median_doubled, medians_ch.held_count,
					medians_ch.dropped);
		end
	end

	initial begin
		arst_n             = 1'b0;
		samples_ch.valid   = 1'b0;
		samples_ch.sample  = '0;
		samples_ch.restart = 1'b0;
		medians_ch.ready   = 1'b0;
		sb = new();
		build_stimulus();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim[i])
			send_sample(stim[i]);
		samples_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
design/rmt_pkg.sv
design/rmt_ifs.sv
design/rmt_cell.sv
design/running_median_tracker_unit.sv
test/testbench.sv
